### sv/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the address resolution cache responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

   localparam int TABLE_DEPTH_DEF = 16;

   localparam int IP_W   = 32;
   localparam int MAC_W  = 48;
   localparam int OP_W   = 16;
   localparam int TAG_W  = 8;
   localparam int KIND_W = 2;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 96;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MAC = 1'b1;

   localparam logic CMD_RESOLVE = 1'b0;
   localparam logic CMD_FRAME   = 1'b1;

   localparam logic [OP_W-1:0] OP_REQUEST = 16'h00FF;
   localparam logic [OP_W-1:0] OP_REPLY   = 16'hFF00;

   localparam logic [KIND_W-1:0] KIND_ANSWER    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BROADCAST = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REPLY     = 2'd2;

   localparam logic [MAC_W-1:0] MAC_BROADCAST = {MAC_W{1'b1}};

   typedef struct packed {
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
      logic             pending;
      logic [TAG_W-1:0] tag;
   } arpc_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_FINISH
   } arpc_state_type;

   typedef enum logic [1:0] {
      MODE_RESOLVE,
      MODE_REQUEST,
      MODE_REPLY
   } arpc_mode_type;

endpackage

### sv/arpc_table.sv
// ----------------------------------------------------------------------------
// arpc_table
// Entry store of the cache: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module arpc_table #(
   parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF,
   parameter int IDX_W       = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  arpc_pkg::arpc_entry_type wr_entry,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output arpc_pkg::arpc_entry_type rd_entry
);
   import arpc_pkg::*;

   arpc_entry_type mem_ff [TABLE_DEPTH];
   arpc_entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

### sv/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: linear table search with one shared compare, update and result.
// ----------------------------------------------------------------------------
module arpc_ctrl #(
   parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF,
   parameter int IDX_W       = 4,
   parameter int CNT_W       = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [arpc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [arpc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [arpc_pkg::KIND_W-1:0]       rsp_tuser,
   input  logic [arpc_pkg::IP_W-1:0]         own_ip,
   output logic                              wr_en,
   output logic [IDX_W-1:0]                  wr_addr,
   output arpc_pkg::arpc_entry_type          wr_entry,
   output logic                              rd_en,
   output logic [IDX_W-1:0]                  rd_addr,
   input  arpc_pkg::arpc_entry_type          rd_entry
);
   import arpc_pkg::*;

   arpc_state_type    state_ff, state_in;
   arpc_mode_type     mode_ff, mode_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              hit_ff, hit_in;

   logic [IP_W-1:0]   qip_ff, sip_ff;
   logic [MAC_W-1:0]  smac_ff;
   logic [TAG_W-1:0]  tag_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [IP_W-1:0]   rsp_ip_ff, rsp_ip_in;
   logic [MAC_W-1:0]  rsp_mac_ff, rsp_mac_in;
   logic              rsp_full_ff, rsp_full_in;

   logic              accept;
   logic              out_load;
   logic              match;
   logic              table_full;
   logic              emit;
   logic [IP_W-1:0]   in_qip, in_sip;
   logic [MAC_W-1:0]  in_smac;
   logic [OP_W-1:0]   in_op;
   logic [TAG_W-1:0]  in_tag;

   assign in_qip  = req_tdata[31:0];
   assign in_sip  = req_tdata[63:32];
   assign in_smac = req_tdata[111:64];
   assign in_op   = req_tdata[127:112];
   assign in_tag  = req_tdata[135:128];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign table_full = (count_ff == CNT_W'(TABLE_DEPTH));

   always_comb begin
      unique case (mode_ff)
         MODE_RESOLVE: match = (rd_entry.ip == qip_ff);
         MODE_REQUEST: match = (rd_entry.ip == sip_ff) && (rd_entry.mac == smac_ff);
         MODE_REPLY:   match = (rd_entry.ip == sip_ff);
         default:      match = 1'b0;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      hit_in      = hit_ff;
      rd_en       = 1'b0;
      rd_addr     = idx_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = idx_ff[IDX_W-1:0];
      wr_entry    = '0;
      emit        = 1'b0;
      out_load    = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_tag_in  = rsp_tag_ff;
      rsp_ip_in   = rsp_ip_ff;
      rsp_mac_in  = rsp_mac_ff;
      rsp_full_in = rsp_full_ff;

      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            hit_in = 1'b0;
            if (accept) begin
               priority if (req_tuser == CMD_RESOLVE) begin
                  mode_in  = MODE_RESOLVE;
                  state_in = ST_SCAN;
               end else if (in_op == OP_REQUEST && in_qip == own_ip) begin
                  mode_in  = MODE_REQUEST;
                  state_in = ST_SCAN;
               end else if (in_op == OP_REPLY) begin
                  mode_in  = MODE_REPLY;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff == count_ff) begin
               state_in = ST_FINISH;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (match) begin
               hit_in   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_FINISH: begin
            unique case (mode_ff)
               MODE_RESOLVE: begin
                  if (hit_ff) begin
                     emit        = (rd_entry.mac != '0);
                     rsp_kind_in = KIND_ANSWER;
                     rsp_tag_in  = tag_ff;
                     rsp_ip_in   = qip_ff;
                     rsp_mac_in  = rd_entry.mac;
                     rsp_full_in = 1'b0;
                  end else begin
                     emit        = 1'b1;
                     rsp_kind_in = KIND_BROADCAST;
                     rsp_tag_in  = '0;
                     rsp_ip_in   = qip_ff;
                     rsp_mac_in  = MAC_BROADCAST;
                     rsp_full_in = table_full;
                     wr_entry    = '{ip: qip_ff, mac: '0, pending: 1'b1, tag: tag_ff};
                  end
               end
               MODE_REQUEST: begin
                  emit        = 1'b1;
                  rsp_kind_in = KIND_REPLY;
                  rsp_tag_in  = '0;
                  rsp_ip_in   = sip_ff;
                  rsp_mac_in  = smac_ff;
                  rsp_full_in = !hit_ff && table_full;
                  wr_entry    = '{ip: sip_ff, mac: smac_ff, pending: 1'b0, tag: '0};
               end
               MODE_REPLY: begin
                  emit        = hit_ff && rd_entry.pending;
                  rsp_kind_in = KIND_ANSWER;
                  rsp_tag_in  = rd_entry.tag;
                  rsp_ip_in   = sip_ff;
                  rsp_mac_in  = smac_ff;
                  rsp_full_in = 1'b0;
                  wr_entry    = '{ip: sip_ff, mac: smac_ff, pending: 1'b0, tag: rd_entry.tag};
               end
               default: begin
                  emit = 1'b0;
               end
            endcase

            if (!emit || !rsp_valid_ff || rsp_tready) begin
               out_load = emit;
               state_in = ST_IDLE;
               if (mode_ff == MODE_REPLY) begin
                  wr_en = hit_ff;
               end else if (!hit_ff && !table_full) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RESOLVE;
         idx_ff       <= '0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         qip_ff  <= in_qip;
         sip_ff  <= in_sip;
         smac_ff <= in_smac;
         tag_ff  <= in_tag;
      end
      if (out_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_tag_ff  <= rsp_tag_in;
         rsp_ip_ff   <= rsp_ip_in;
         rsp_mac_ff  <= rsp_mac_in;
         rsp_full_ff <= rsp_full_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {7'b0, rsp_full_ff, rsp_mac_ff, rsp_ip_ff, rsp_tag_ff};

endmodule

### sv/arp_cache_responder.sv
// ----------------------------------------------------------------------------
// arp_cache_responder
// Address resolution cache with a responder for client resolves and frames.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  req_     in   tuser: command; tdata: query_ip, peer_ip, peer_mac,
//                op_code, client_tag
//  rsp_     out  tuser: result_kind; tdata: dest_tag, dest_ip, resolved_mac,
//                table_full
//  csr_     in   index 0 own_ip, index 1 own_mac
//
//  An item is searched entry by entry: ST_SCAN reads an entry, ST_CHECK
//  compares it, and a hit or the end of the table leads to ST_FINISH; the
//  search is set by the single table read port and compare.
//  Ignored frames return straight to idle. req_tready is high only when idle.
//  A finished result waits in the output register; the block stalls only if
//  a new result meets a full output register. Reset empties the table.
// ----------------------------------------------------------------------------
module arp_cache_responder #(
   parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // query_ip[31:0], peer_ip[63:32], peer_mac[111:64], op_code[127:112],
   // client_tag[135:128]
   input  logic [arpc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // dest_tag[7:0], dest_ip[39:8], resolved_mac[87:40], table_full[88], zero above
   output logic [arpc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // result_kind
   output logic [arpc_pkg::KIND_W-1:0]       rsp_tuser,
   input  logic                              csr_we,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import arpc_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [IP_W-1:0]  own_ip_ff;
   logic [MAC_W-1:0] own_mac_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   arpc_entry_type   wr_entry;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   arpc_entry_type   rd_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff  <= '0;
         own_mac_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_IP:  own_ip_ff  <= csr_wdata[IP_W-1:0];
            CSR_OWN_MAC: own_mac_ff <= csr_wdata[MAC_W-1:0];
            default:     own_ip_ff  <= own_ip_ff;
         endcase
      end
   end

   arpc_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .own_ip     (own_ip_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_entry   (wr_entry),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_entry   (rd_entry)
   );

   arpc_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the address resolution cache responder with a directed table of
// resolve and frame beats, then random traffic that mostly targets addresses
// already in the cache. Every accepted beat runs through a local cache model.
// Fixed rows queue their own answer, others the model's; rsp beats check in order.
// ----------------------------------------------------------------------------
module tb_top;
   import arpc_pkg::*;

   localparam int DEPTH           = TABLE_DEPTH_DEF;
   localparam int SETTLE          = 2 * DEPTH + 8;
   localparam int ITEMS_PER_PHASE = 355;
   localparam int N_DIRECTED      = 25;
   localparam bit FIXED           = 1'b1;
   localparam bit PRED            = 1'b0;
   localparam bit RSP             = 1'b1;
   localparam bit NO_RSP          = 1'b0;

   typedef struct packed {
      logic             cmd;
      logic [IP_W-1:0]  qip;
      logic [IP_W-1:0]  sip;
      logic [MAC_W-1:0] smac;
      logic [OP_W-1:0]  op;
      logic [TAG_W-1:0] tag;
   } arp_item_t;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TAG_W-1:0]  tag;
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
      logic              full;
   } arp_answer_t;

   typedef struct packed {
      logic              cmd;
      logic [IP_W-1:0]   qip;
      logic [IP_W-1:0]   sip;
      logic [MAC_W-1:0]  smac;
      logic [OP_W-1:0]   op;
      logic [TAG_W-1:0]  tag;
      logic [4:0]        reps;
      logic              fixed;
      logic              has_rsp;
      logic [KIND_W-1:0] kind;
      logic [TAG_W-1:0]  dtag;
      logic [IP_W-1:0]   dip;
      logic [MAC_W-1:0]  dmac;
      logic              full;
   } probe_row_t;

   // own_ip is 32'hC0A8_0001 while this table runs
   localparam probe_row_t DIRECTED [N_DIRECTED] = '{
      '{CMD_RESOLVE, 32'h0000_0000, 32'h0, 48'h0, 16'h0000, 8'h00, 5'd1,
        FIXED, RSP, KIND_BROADCAST, 8'h00, 32'h0000_0000, MAC_BROADCAST, 1'b0},
      '{CMD_RESOLVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
        8'hFF, 5'd1,
        FIXED, RSP, KIND_BROADCAST, 8'h00, 32'hFFFF_FFFF, MAC_BROADCAST, 1'b0},
      '{CMD_RESOLVE, 32'h0000_0000, 32'h0, 48'h0, 16'h0000, 8'h5A, 5'd1,
        FIXED, NO_RSP, KIND_ANSWER, 8'h00, 32'h0, 48'h0, 1'b0},
      '{CMD_FRAME, 32'h0000_0000, 32'h0000_0000, 48'h0000_0000_0001, OP_REPLY,
        8'h00, 5'd1,
        FIXED, RSP, KIND_ANSWER, 8'h00, 32'h0000_0000, 48'h0000_0000_0001, 1'b0},
      '{CMD_RESOLVE, 32'h0000_0000, 32'h0, 48'h0, 16'h0000, 8'hA5, 5'd1,
        FIXED, RSP, KIND_ANSWER, 8'hA5, 32'h0000_0000, 48'h0000_0000_0001, 1'b0},
      '{CMD_FRAME, 32'h0000_0000, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, OP_REPLY,
        8'h00, 5'd1,
        FIXED, NO_RSP, KIND_ANSWER, 8'h00, 32'h0, 48'h0, 1'b0},
      '{CMD_RESOLVE, 32'h0000_0000, 32'h0, 48'h0, 16'h0000, 8'h3C, 5'd1,
        FIXED, RSP, KIND_ANSWER, 8'h3C, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0},
      '{CMD_FRAME, 32'hC0A8_0001, 32'h0A00_0001, 48'h0000_1111_2222, OP_REQUEST,
        8'hEE, 5'd1,
        FIXED, RSP, KIND_REPLY, 8'h00, 32'h0A00_0001, 48'h0000_1111_2222, 1'b0},
      '{CMD_FRAME, 32'hC0A8_0001, 32'h0A00_0001, 48'h0000_1111_2222, OP_REQUEST,
        8'h00, 5'd1,
        FIXED, RSP, KIND_REPLY, 8'h00, 32'h0A00_0001, 48'h0000_1111_2222, 1'b0},
      '{CMD_FRAME, 32'hC0A8_0001, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, OP_REQUEST,
        8'h00, 5'd1,
        FIXED, RSP, KIND_REPLY, 8'h00, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0},
      '{CMD_FRAME, 32'hC0A8_0002, 32'h0A00_0009, 48'h0000_0000_0001, OP_REQUEST,
        8'h00, 5'd1,
        FIXED, NO_RSP, KIND_ANSWER, 8'h00, 32'h0, 48'h0, 1'b0},
      '{CMD_FRAME, 32'hC0A8_0001, 32'h0B00_0001, 48'h0000_0000_0002, OP_REPLY,
        8'h00, 5'd1,
        FIXED, NO_RSP, KIND_ANSWER, 8'h00, 32'h0, 48'h0, 1'b0},
      '{CMD_FRAME, 32'hC0A8_0001, 32'h0A00_0001, 48'h0000_1111_2222, 16'h0000,
        8'h00, 5'd1,
        FIXED, NO_RSP, KIND_ANSWER, 8'h00, 32'h0, 48'h0, 1'b0},
      '{CMD_FRAME, 32'hC0A8_0001, 32'h0000_0000, 48'h0, 16'hFFFF, 8'h00, 5'd1,
        FIXED, NO_RSP, KIND_ANSWER, 8'h00, 32'h0, 48'h0, 1'b0},
      '{CMD_FRAME, 32'h0000_0000, 32'hFFFF_FFFF, 48'h0000_0000_0000, OP_REPLY,
        8'h00, 5'd1,
        FIXED, RSP, KIND_ANSWER, 8'hFF, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0},
      '{CMD_RESOLVE, 32'hFFFF_FFFF, 32'h0, 48'h0, 16'h0000, 8'h11, 5'd1,
        FIXED, NO_RSP, KIND_ANSWER, 8'h00, 32'h0, 48'h0, 1'b0},
      '{CMD_RESOLVE, 32'h0A00_0001, 32'h1234_5678, 48'hDEAD_BEEF_0000, OP_REQUEST,
        8'h77, 5'd1,
        FIXED, RSP, KIND_ANSWER, 8'h77, 32'h0A00_0001, 48'h0000_1111_2222, 1'b0},
      '{CMD_FRAME, 32'hC0A8_0001, 32'h0A00_0001, 48'h0000_3333_4444, OP_REQUEST,
        8'h00, 5'd1,
        FIXED, RSP, KIND_REPLY, 8'h00, 32'h0A00_0001, 48'h0000_3333_4444, 1'b0},
      '{CMD_FRAME, 32'h0000_0000, 32'h0A00_0001, 48'h0000_ABCD_0000, OP_REPLY,
        8'h00, 5'd1,
        FIXED, NO_RSP, KIND_ANSWER, 8'h00, 32'h0, 48'h0, 1'b0},
      '{CMD_RESOLVE, 32'h0A00_0001, 32'h0, 48'h0, 16'h0000, 8'h01, 5'd1,
        FIXED, RSP, KIND_ANSWER, 8'h01, 32'h0A00_0001, 48'h0000_ABCD_0000, 1'b0},
      '{CMD_RESOLVE, 32'h0A0A_0000, 32'h0, 48'h0, 16'h0000, 8'h40, 5'd12,
        PRED, NO_RSP, KIND_ANSWER, 8'h00, 32'h0, 48'h0, 1'b0},
      '{CMD_RESOLVE, 32'h0D00_0000, 32'h0, 48'h0, 16'h0000, 8'h99, 5'd1,
        FIXED, RSP, KIND_BROADCAST, 8'h00, 32'h0D00_0000, MAC_BROADCAST, 1'b1},
      '{CMD_FRAME, 32'hC0A8_0001, 32'h0E00_0001, 48'h0000_5555_5555, OP_REQUEST,
        8'h00, 5'd1,
        FIXED, RSP, KIND_REPLY, 8'h00, 32'h0E00_0001, 48'h0000_5555_5555, 1'b1},
      '{CMD_FRAME, 32'h0000_0000, 32'h0A0A_0005, 48'h1234_5678_9ABC, OP_REPLY,
        8'h00, 5'd1,
        PRED, NO_RSP, KIND_ANSWER, 8'h00, 32'h0, 48'h0, 1'b0},
      '{CMD_RESOLVE, 32'h0D00_0000, 32'h0, 48'h0, 16'h0000, 8'h9A, 5'd1,
        PRED, NO_RSP, KIND_ANSWER, 8'h00, 32'h0, 48'h0, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = CMD_RESOLVE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_OWN_IP;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [IP_W-1:0]  cache_ip   [DEPTH];
   logic [MAC_W-1:0] cache_mac  [DEPTH];
   logic             cache_pend [DEPTH];
   logic [TAG_W-1:0] cache_tag  [DEPTH];
   int               cache_count = 0;
   logic [IP_W-1:0]  cfg_ip  = '0;
   logic [MAC_W-1:0] cfg_mac = '0;

   arp_answer_t answers_due [$];
   int          mismatches = 0;
   bit          steady     = 1'b0;

   arp_cache_responder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int first_with_ip(input logic [IP_W-1:0] ip);
      for (int i = 0; i < cache_count; i++)
         if (cache_ip[i] == ip) return i;
      return -1;
   endfunction

   function automatic int first_with_pair(input logic [IP_W-1:0] ip,
                                          input logic [MAC_W-1:0] mac);
      for (int i = 0; i < cache_count; i++)
         if (cache_ip[i] == ip && cache_mac[i] == mac) return i;
      return -1;
   endfunction

   function automatic bit cache_add(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
                                    input logic pend, input logic [TAG_W-1:0] tag);
      if (cache_count >= DEPTH) return 1'b0;
      cache_ip[cache_count]   = ip;
      cache_mac[cache_count]  = mac;
      cache_pend[cache_count] = pend;
      cache_tag[cache_count]  = tag;
      cache_count++;
      return 1'b1;
   endfunction

   // apply one beat to the cache copy; returns 1 when the beat yields a response
   function automatic bit cache_step(input arp_item_t it, output arp_answer_t ans);
      int idx;
      bit ok;
      ans = '0;
      if (it.cmd == CMD_RESOLVE) begin
         idx = first_with_ip(it.qip);
         if (idx < 0) begin
            ok = cache_add(it.qip, '0, 1'b1, it.tag);
            ans = '{KIND_BROADCAST, 8'h00, it.qip, MAC_BROADCAST, !ok};
            return 1'b1;
         end
         if (cache_mac[idx] == '0) return 1'b0;
         ans = '{KIND_ANSWER, it.tag, it.qip, cache_mac[idx], 1'b0};
         return 1'b1;
      end
      if (it.op == OP_REQUEST) begin
         if (it.qip != cfg_ip) return 1'b0;
         ok = 1'b1;
         if (first_with_pair(it.sip, it.smac) < 0)
            ok = cache_add(it.sip, it.smac, 1'b0, 8'h00);
         ans = '{KIND_REPLY, 8'h00, it.sip, it.smac, !ok};
         return 1'b1;
      end
      if (it.op == OP_REPLY) begin
         idx = first_with_ip(it.sip);
         if (idx < 0) return 1'b0;
         cache_mac[idx] = it.smac;
         if (!cache_pend[idx]) return 1'b0;
         cache_pend[idx] = 1'b0;
         ans = '{KIND_ANSWER, cache_tag[idx], it.sip, it.smac, 1'b0};
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic arp_item_t random_item();
      arp_item_t   it;
      logic [63:0] wide;
      int          roll;
      int          pick;
      wide    = {$urandom, $urandom};
      it.cmd  = ($urandom_range(0, 9) < 4) ? CMD_RESOLVE : CMD_FRAME;
      it.qip  = $urandom;
      it.sip  = $urandom;
      it.smac = wide[MAC_W-1:0];
      it.op   = OP_W'($urandom);
      it.tag  = TAG_W'($urandom);
      roll    = $urandom_range(0, 99);
      pick    = (cache_count > 0) ? $urandom_range(0, cache_count - 1) : 0;
      if (it.cmd == CMD_RESOLVE) begin
         if (roll < 65 && cache_count > 0) it.qip = cache_ip[pick];
         else if (roll < 75) it.qip = roll[0] ? '1 : '0;
      end else if (roll < 45) begin
         it.op = OP_REQUEST;
         if ($urandom_range(0, 9) < 8) it.qip = cfg_ip;
         roll = $urandom_range(0, 9);
         if (roll < 4 && cache_count > 0) begin
            it.sip  = cache_ip[pick];
            it.smac = cache_mac[pick];
         end else if (roll < 6 && cache_count > 0) begin
            it.sip = cache_ip[pick];
         end
      end else if (roll < 88) begin
         it.op = OP_REPLY;
         if ($urandom_range(0, 9) < 8 && cache_count > 0) it.sip = cache_ip[pick];
      end
      roll = $urandom_range(0, 19);
      if (roll < 3) it.smac = '0;
      else if (roll == 3) it.smac = '1;
      return it;
   endfunction

   task automatic send_item(input arp_item_t it);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {it.tag, it.op, it.smac, it.sip, it.qip};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_node(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
      csr_we    <= 1'b1;
      csr_index <= CSR_OWN_IP;
      csr_wdata <= {{(CSR_DATA_W-IP_W){1'b0}}, ip};
      @(posedge clock);
      csr_index <= CSR_OWN_MAC;
      csr_wdata <= mac;
      @(posedge clock);
      csr_we  <= 1'b0;
      cfg_ip  = ip;
      cfg_mac = mac;
   endtask

   task automatic flag_field(input string name, input logic [MAC_W-1:0] want,
                             input logic [MAC_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      arp_answer_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answers_due.size() == 0) begin
            $display("%0t: rsp beat expected none actual kind %h data %h",
                     $time, rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = answers_due.pop_front();
            flag_field("result_kind", MAC_W'(want.kind), MAC_W'(rsp_tuser));
            flag_field("dest_tag", MAC_W'(want.tag), MAC_W'(rsp_tdata[7:0]));
            flag_field("dest_ip", MAC_W'(want.ip), MAC_W'(rsp_tdata[39:8]));
            flag_field("resolved_mac", want.mac, rsp_tdata[87:40]);
            flag_field("table_full", MAC_W'(want.full), MAC_W'(rsp_tdata[88]));
            flag_field("rsp pad", '0, MAC_W'(rsp_tdata[RSP_DATA_W-1:89]));
         end
      end
   end

   initial begin : rsp_ready
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("arp_cache_responder regression: fail");
      $finish;
   end

   initial begin : stimulus
      arp_item_t   it;
      arp_answer_t ans;
      probe_row_t  row;
      logic [63:0] wide;
      int          counted;
      int          beats;
      bit          has;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      program_node(32'hC0A8_0001, 48'h0200_0000_0001);
      for (int r = 0; r < N_DIRECTED; r++) begin
         row = DIRECTED[r];
         for (int k = 0; k < row.reps; k++) begin
            it = '{row.cmd, row.qip + IP_W'(k), row.sip, row.smac, row.op,
                   row.tag + TAG_W'(k)};
            send_item(it);
            has = cache_step(it, ans);
            if (row.fixed) begin
               if (row.has_rsp)
                  answers_due.push_back('{row.kind, row.dtag, row.dip, row.dmac, row.full});
            end else if (has) begin
               answers_due.push_back(ans);
            end
         end
      end
      quiesce();

      for (int p = 0; p < 4; p++) begin
         wide = {$urandom, $urandom};
         case (p)
            0: program_node('1, '1);
            1: program_node('0, '0);
            default: program_node($urandom, wide[MAC_W-1:0]);
         endcase
         counted = 0;
         beats   = 0;
         while (counted < ITEMS_PER_PHASE) begin
            if (beats % 64 == 0) steady = ($urandom_range(0, 3) == 0);
            it = random_item();
            send_item(it);
            if (cache_step(it, ans)) answers_due.push_back(ans);
            if (!(it.cmd == CMD_FRAME && it.op != OP_REQUEST && it.op != OP_REPLY))
               counted++;
            beats++;
            if ($urandom_range(0, 59) == 0) quiesce();
         end
         quiesce();
      end

      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("arp_cache_responder regression: pass");
      end else begin
         $display("arp_cache_responder regression: fail");
      end
      $finish;
   end

endmodule

### sim.f
sv/arpc_pkg.sv
sv/arpc_table.sv
sv/arpc_ctrl.sv
sv/arp_cache_responder.sv
dv/tb_top.sv
